// ----- design/relo_pkg.sv -----
// Shared types, constants and helpers for the ring entry offset locator.
package relo_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Field widths
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 20;

    // Request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [HANDLE_W-1:0] new_handle;
        logic [SIZE_W-1:0]   new_size;
        logic [OFFS_W-1:0]   char_pos;
    } req_t;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] hit_handle;
        logic [SIZE_W-1:0]   hit_size;
        logic [SIZE_W-1:0]   byte_in_entry;
        logic [HANDLE_W-1:0] evicted_handle;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND
    } state_t;

    // Step a ring index forward with wrap
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(RING_DEPTH - 1))
            nxt = '0;
        else
            nxt = idx + 1'b1;
        return nxt;
    endfunction

endpackage

// ----- design/ring_entry_offset_locator_core.sv -----
// Top level of the ring entry offset locator: entry store, indices and walk sequencer.
//
// A transfer is taken when start is high and busy is low. An add reads the old
// slot, then writes it back; a find examines live entries from the oldest, up to
// the hit or the newest, reading one entry per cycle through the single read port
// of the entry memory. A find on an empty ring reports not found at once. Each
// result appears on rsp marked by done, high for exactly one cycle in the cycle
// after the last working cycle; the receiver cannot stall it and must take it then.
// Per-entry valid bits cleared at reset make unwritten slots read as zero, so
// no clearing pass follows reset.
module ring_entry_offset_locator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  relo_pkg::req_t req,
    output logic           done,
    output relo_pkg::rsp_t rsp
);

    localparam int IDX_W    = relo_pkg::IDX_W;
    localparam int CNT_W    = relo_pkg::CNT_W;
    localparam int HANDLE_W = relo_pkg::HANDLE_W;
    localparam int SIZE_W   = relo_pkg::SIZE_W;
    localparam int OFFS_W   = relo_pkg::OFFS_W;
    localparam int DEPTH    = relo_pkg::RING_DEPTH;

    // Entry memory: {handle, size}
    logic [HANDLE_W+SIZE_W-1:0] mem [DEPTH];
    logic [HANDLE_W+SIZE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic [DEPTH-1:0]           valid_reg;

    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [HANDLE_W+SIZE_W-1:0] wr_data;

    relo_pkg::state_t           state_reg, state_next;
    logic [IDX_W-1:0]           widx_reg, widx_next;
    logic [IDX_W-1:0]           ridx_reg, ridx_next;
    logic                       full_reg, full_next;
    logic [IDX_W-1:0]           walk_reg, walk_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [OFFS_W-1:0]          rem_reg, rem_next;
    logic [HANDLE_W-1:0]        add_handle_reg, add_handle_next;
    logic [SIZE_W-1:0]          add_size_reg, add_size_next;
    logic                       done_reg, done_next;
    relo_pkg::rsp_t             rsp_reg, rsp_next;

    logic [HANDLE_W-1:0]        rd_handle;
    logic [SIZE_W-1:0]          rd_size;

    // Mask entries never written since reset
    assign rd_handle = rd_valid_reg ? rd_data_reg[HANDLE_W+SIZE_W-1:SIZE_W] : '0;
    assign rd_size   = rd_valid_reg ? rd_data_reg[SIZE_W-1:0] : '0;

    assign busy = (state_reg != relo_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Write and read the entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Hold the valid bits and the valid flag of the read entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= relo_pkg::ST_IDLE;
            widx_reg  <= '0;
            ridx_reg  <= '0;
            full_reg  <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg  <= widx_next;
            ridx_reg  <= ridx_next;
            full_reg  <= full_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        walk_reg       <= walk_next;
        rem_reg        <= rem_next;
        add_handle_reg <= add_handle_next;
        add_size_reg   <= add_size_next;
        rsp_reg        <= rsp_next;
    end

    // Sequence adds and finds
    always_comb
    begin
        logic [CNT_W-1:0] live;
        logic [IDX_W-1:0] step_idx;

        state_next      = state_reg;
        widx_next       = widx_reg;
        ridx_next       = ridx_reg;
        full_next       = full_reg;
        walk_next       = walk_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        add_handle_next = add_handle_reg;
        add_size_next   = add_size_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        rd_addr         = walk_reg;
        wr_en           = 1'b0;
        wr_addr         = widx_reg;
        wr_data         = {add_handle_reg, add_size_reg};
        step_idx        = relo_pkg::next_slot(walk_reg);

        // Count live entries from the indices
        if (full_reg)
            live = CNT_W'(DEPTH);
        else if (widx_reg >= ridx_reg)
            live = CNT_W'(widx_reg) - CNT_W'(ridx_reg);
        else
            live = CNT_W'(widx_reg) + CNT_W'(DEPTH) - CNT_W'(ridx_reg);

        case (state_reg)
            relo_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == relo_pkg::REQ_ADD)
                    begin
                        // Read the old slot contents first
                        add_handle_next = req.new_handle;
                        add_size_next   = req.new_size;
                        rd_addr         = widx_reg;
                        state_next      = relo_pkg::ST_ADD;
                    end
                    else if (live == '0)
                    begin
                        // Empty ring: report not found at once
                        rsp_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr    = ridx_reg;
                        walk_next  = ridx_reg;
                        cnt_next   = live;
                        rem_next   = req.char_pos;
                        state_next = relo_pkg::ST_FIND;
                    end
                end
            end

            relo_pkg::ST_ADD:
            begin
                // Write back the new entry and advance the indices
                wr_en     = 1'b1;
                rsp_next  = '0;
                rsp_next.evicted_handle = rd_handle;
                done_next = 1'b1;
                widx_next = relo_pkg::next_slot(widx_reg);
                if (full_reg)
                    ridx_next = relo_pkg::next_slot(ridx_reg);
                full_next  = (widx_next == ridx_next);
                state_next = relo_pkg::ST_IDLE;
            end

            relo_pkg::ST_FIND:
            begin
                if ({{(OFFS_W-SIZE_W){1'b0}}, rd_size} > rem_reg)
                begin
                    // Hit: the entry holds the character
                    rsp_next               = '0;
                    rsp_next.found         = 1'b1;
                    rsp_next.hit_handle    = rd_handle;
                    rsp_next.hit_size      = rd_size;
                    rsp_next.byte_in_entry = rem_reg[SIZE_W-1:0];
                    done_next              = 1'b1;
                    state_next             = relo_pkg::ST_IDLE;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    // Walked past the newest entry
                    rsp_next   = '0;
                    done_next  = 1'b1;
                    state_next = relo_pkg::ST_IDLE;
                end
                else
                begin
                    // Advance to the next entry
                    rem_next  = rem_reg - {{(OFFS_W-SIZE_W){1'b0}}, rd_size};
                    cnt_next  = cnt_reg - 1'b1;
                    walk_next = step_idx;
                    rd_addr   = step_idx;
                end
            end

            default:
            begin
                state_next = relo_pkg::ST_IDLE;
            end
        endcase
    end

    // A full ring has its indices equal
    a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (widx_reg == ridx_reg))
        else $error("ring full with indices apart");

    // The walk never runs with no entries left
    a_walk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == relo_pkg::ST_FIND) |-> (cnt_reg != '0))
        else $error("find walk with zero count");

    // An add state is followed by a result and a return to idle
    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == relo_pkg::ST_ADD) |=> (done && state_reg == relo_pkg::ST_IDLE))
        else $error("add did not complete");

    // A hit never reports an evicted handle
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.found) |-> (rsp.evicted_handle == '0))
        else $error("hit result carries evicted handle");

    // A result follows only accepted work
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(state_reg != relo_pkg::ST_IDLE)))
        else $error("result without a transfer");

endmodule

// ----- sim/ring_entry_offset_locator_core_test.sv -----
// Self-checking testbench for the ring entry offset locator core.
`timescale 1ns / 1ps

module ring_entry_offset_locator_core_test;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_LIMIT   = 500;

    typedef struct {
        relo_pkg::req_t req;
        bit             typed;
        relo_pkg::rsp_t rsp;
    } plan_row_t;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic           done;
    relo_pkg::req_t req   = '0;
    relo_pkg::rsp_t rsp;

    // Ring image kept in step with every request transfer
    logic [relo_pkg::HANDLE_W-1:0] slot_handle [relo_pkg::RING_DEPTH];
    logic [relo_pkg::SIZE_W-1:0]   slot_size   [relo_pkg::RING_DEPTH];
    logic [relo_pkg::IDX_W-1:0]    wr_slot;
    logic [relo_pkg::IDX_W-1:0]    rd_slot;
    logic                          ring_is_full;

    relo_pkg::rsp_t staged_rsp;
    relo_pkg::rsp_t oldest_rsp;
    relo_pkg::rsp_t awaited_rsp [$];
    plan_row_t      plan [DIRECTED_ROWS];
    int             transfers_in = 0;
    int             quiet_cycles = 0;
    int             mismatches   = 0;

    ring_entry_offset_locator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    function automatic logic [relo_pkg::IDX_W-1:0] step_slot(
        input logic [relo_pkg::IDX_W-1:0] s);
        return relo_pkg::IDX_W'((int'(s) + 1) % relo_pkg::RING_DEPTH);
    endfunction

    function automatic int live_entries();
        if (ring_is_full)
            return relo_pkg::RING_DEPTH;
        return (int'(wr_slot) + relo_pkg::RING_DEPTH - int'(rd_slot)) % relo_pkg::RING_DEPTH;
    endfunction

    // Sum the sizes of the oldest k live entries
    function automatic int bytes_before(input int k);
        int total;
        int n;
        logic [relo_pkg::IDX_W-1:0] idx;
        total = 0;
        idx = rd_slot;
        for (n = 0; n < k; n++)
        begin
            total += int'(slot_size[idx]);
            idx = step_slot(idx);
        end
        return total;
    endfunction

    // Apply one request to the ring image and return the response it should produce
    function automatic relo_pkg::rsp_t ring_outcome(input relo_pkg::req_t r);
        relo_pkg::rsp_t o;
        logic [relo_pkg::OFFS_W-1:0] left;
        logic [relo_pkg::IDX_W-1:0]  idx;
        int live;
        int n;
        o = '0;
        if (r.req_type == relo_pkg::REQ_ADD)
        begin
            // overwrite the oldest entry when full
            if (ring_is_full)
                rd_slot = step_slot(rd_slot);
            o.evicted_handle = slot_handle[wr_slot];
            slot_handle[wr_slot] = r.new_handle;
            slot_size[wr_slot] = r.new_size;
            wr_slot = step_slot(wr_slot);
            ring_is_full = (wr_slot == rd_slot);
        end
        else
        begin
            // walk oldest to newest until an entry is larger than what is left
            left = r.char_pos;
            idx = rd_slot;
            live = live_entries();
            for (n = 0; n < live; n++)
            begin
                if (!o.found)
                begin
                    if (relo_pkg::OFFS_W'(slot_size[idx]) > left)
                    begin
                        o.found = 1'b1;
                        o.hit_handle = slot_handle[idx];
                        o.hit_size = slot_size[idx];
                        o.byte_in_entry = left[relo_pkg::SIZE_W-1:0];
                    end
                    else
                    begin
                        left = left - relo_pkg::OFFS_W'(slot_size[idx]);
                        idx = step_slot(idx);
                    end
                end
            end
        end
        return o;
    endfunction

    // Draw a request: adds of mostly small sizes, finds aimed at live data and boundaries
    function automatic relo_pkg::req_t pick_request();
        relo_pkg::req_t r;
        int roll;
        int live;
        int span;
        int off;
        r.req_type = ($urandom_range(0, 99) < 45) ? relo_pkg::REQ_ADD : relo_pkg::REQ_FIND;
        r.new_handle = $urandom();
        r.new_size = relo_pkg::SIZE_W'($urandom());
        r.char_pos = relo_pkg::OFFS_W'($urandom());
        roll = $urandom_range(0, 99);
        if (r.req_type == relo_pkg::REQ_ADD)
        begin
            if (roll < 10)
                r.new_size = '0;
            else if (roll < 15)
                r.new_size = '1;
            else if (roll < 80)
                r.new_size = relo_pkg::SIZE_W'($urandom_range(1, 64));
        end
        else
        begin
            live = live_entries();
            span = bytes_before(live);
            if (roll < 40)
                r.char_pos = relo_pkg::OFFS_W'($urandom_range(0, (span > 0) ? span - 1 : 0));
            else if (roll < 65)
            begin
                off = bytes_before($urandom_range(0, live));
                if (off > 0 && $urandom_range(0, 1) == 1)
                    off--;
                r.char_pos = relo_pkg::OFFS_W'(off);
            end
            else if (roll < 80)
                r.char_pos = relo_pkg::OFFS_W'($urandom());
            else if (roll < 90)
                r.char_pos = relo_pkg::OFFS_W'(span);
            else
                r.char_pos = '1;
        end
        return r;
    endfunction

    function automatic plan_row_t plan_row(input logic kind, input logic [31:0] h,
                                           input logic [15:0] s, input logic [19:0] o,
                                           input bit typed, input logic hit,
                                           input logic [31:0] hit_h, input logic [15:0] hit_s,
                                           input logic [15:0] byte_at,
                                           input logic [31:0] evicted);
        plan_row_t p;
        p.req = '{req_type: kind, new_handle: h, new_size: s, char_pos: o};
        p.typed = typed;
        p.rsp = '{found: hit, hit_handle: hit_h, hit_size: hit_s,
                  byte_in_entry: byte_at, evicted_handle: evicted};
        return p;
    endfunction

    // Present one request and hold it until the transfer is taken
    task automatic issue(input relo_pkg::req_t r, input bit typed,
                         input relo_pkg::rsp_t typed_rsp);
        int target;
        relo_pkg::rsp_t model_rsp;
        model_rsp = ring_outcome(r);
        staged_rsp = typed ? typed_rsp : model_rsp;
        target = transfers_in + 1;
        start <= 1'b1;
        req <= r;
        do
            @(negedge clk);
        while (transfers_in < target);
    endtask

    // Record request transfers and check response transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                awaited_rsp.push_back(staged_rsp);
                transfers_in++;
            end
            if (done)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("response transfer with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    oldest_rsp = awaited_rsp.pop_front();
                    if (rsp.found !== oldest_rsp.found)
                    begin
                        $error("found: expected %0h, got %0h", oldest_rsp.found, rsp.found);
                        mismatches++;
                    end
                    if (rsp.hit_handle !== oldest_rsp.hit_handle)
                    begin
                        $error("hit_handle: expected %0h, got %0h",
                               oldest_rsp.hit_handle, rsp.hit_handle);
                        mismatches++;
                    end
                    if (rsp.hit_size !== oldest_rsp.hit_size)
                    begin
                        $error("hit_size: expected %0h, got %0h",
                               oldest_rsp.hit_size, rsp.hit_size);
                        mismatches++;
                    end
                    if (rsp.byte_in_entry !== oldest_rsp.byte_in_entry)
                    begin
                        $error("byte_in_entry: expected %0h, got %0h",
                               oldest_rsp.byte_in_entry, rsp.byte_in_entry);
                        mismatches++;
                    end
                    if (rsp.evicted_handle !== oldest_rsp.evicted_handle)
                    begin
                        $error("evicted_handle: expected %0h, got %0h",
                               oldest_rsp.evicted_handle, rsp.evicted_handle);
                        mismatches++;
                    end
                end
            end
            quiet_cycles = ((start && !busy) || done) ? 0 : quiet_cycles + 1;
        end
    end

    // Abort when no transfer happens for too long
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ring_entry_offset_locator_core_test NOT OK");
        $finish;
    end

    initial
    begin
        int i;
        int issued;
        int burst;
        int b;

        // Cleared ring image matches the state after reset
        for (i = 0; i < relo_pkg::RING_DEPTH; i++)
        begin
            slot_handle[i] = '0;
            slot_size[i] = '0;
        end
        wr_slot = '0;
        rd_slot = '0;
        ring_is_full = 1'b0;

        plan = '{
            // empty ring, lowest and highest offset
            plan_row(relo_pkg::REQ_FIND, 32'hDEADBEEF, 16'h1234, 20'h00000,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_FIND, 32'h00000000, 16'h0000, 20'hFFFFF,
                     1, 0, 0, 0, 0, 0),
            // largest entry, zero-size entry, one-byte entry
            plan_row(relo_pkg::REQ_ADD,  32'hFFFFFFFF, 16'hFFFF, 20'hABCDE,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h00000000, 16'h0000, 20'h00000,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h00000001, 16'h0001, 20'hFFFFF,
                     1, 0, 0, 0, 0, 0),
            // first and last byte of the largest entry
            plan_row(relo_pkg::REQ_FIND, 32'h13572468, 16'hFFFF, 20'h00000,
                     1, 1, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 0),
            plan_row(relo_pkg::REQ_FIND, 32'h00000000, 16'h0000, 20'h0FFFE,
                     1, 1, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFE, 0),
            // boundary past a zero-size entry, just past the data, far past it
            plan_row(relo_pkg::REQ_FIND, 32'h00000000, 16'h0000, 20'h0FFFF,
                     0, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_FIND, 32'h00000000, 16'h0000, 20'h10000,
                     0, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_FIND, 32'hFFFFFFFF, 16'hFFFF, 20'hFFFFF,
                     0, 0, 0, 0, 0, 0),
            // fill the ring
            plan_row(relo_pkg::REQ_ADD,  32'h80000001, 16'h0002, 20'h55555,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h7FFFFFFE, 16'h0003, 20'hAAAAA,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h12345678, 16'h0005, 20'h12345,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h9ABCDEF0, 16'h0008, 20'hFEDCB,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h0F0F0F0F, 16'h000D, 20'h00001,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'hF0F0F0F0, 16'h0015, 20'h80000,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h33333333, 16'h0022, 20'h7FFFF,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'hCCCCCCCC, 16'h0037, 20'h3C3C3,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h55AA55AA, 16'h0059, 20'hC3C3C,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'hAA55AA55, 16'h0090, 20'h0F0F0,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h01020304, 16'h00E9, 20'hF0F0F,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'hFEDCBA98, 16'h0179, 20'h11111,
                     1, 0, 0, 0, 0, 0),
            plan_row(relo_pkg::REQ_ADD,  32'h76543210, 16'h0262, 20'hEEEEE,
                     1, 0, 0, 0, 0, 0),
            // add to a full ring overwrites the oldest entry
            plan_row(relo_pkg::REQ_ADD,  32'h5A5A5A5A, 16'h0007, 20'h24680,
                     1, 0, 0, 0, 0, 32'hFFFFFFFF),
            plan_row(relo_pkg::REQ_FIND, 32'hFFFFFFFF, 16'hFFFF, 20'h00000,
                     0, 0, 0, 0, 0, 0)
        };

        // Hold reset, then release it away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table with occasional idle cycles
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue(plan[i].req, plan[i].typed, plan[i].rsp);
            if ($urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end

        // Random requests in bursts, sometimes back to back
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (b = 0; b < burst && issued < RANDOM_ITEMS; b++)
            begin
                issue(pick_request(), 1'b0, '0);
                issued++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
        start <= 1'b0;

        // Drain outstanding responses, then allow for stray ones
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (relo_pkg::RING_DEPTH + 4) @(posedge clk);

        if (mismatches == 0)
            $display("ring_entry_offset_locator_core_test OK");
        else
            $display("ring_entry_offset_locator_core_test NOT OK");
        $finish;
    end

endmodule
